### rtl/ghaq_pkg.sv
// ghaq_pkg: shared types, codes and reset values of the gas/heat alarm qualifier.
// No dependencies; every other file in rtl/ uses it through scoped names.
package ghaq_pkg;

   typedef logic [1:0]         opcode_type;
   typedef logic [1:0]         mode_type;
   typedef logic [7:0]         count_type;
   typedef logic [15:0]        ppm_type;
   typedef logic signed [15:0] temp_type;
   typedef logic [2:0]         csr_addr_type;
   typedef logic [15:0]        csr_data_type;

   // opcodes
   localparam opcode_type OP_EVAL   = 2'd0;
   localparam opcode_type OP_ERROR  = 2'd1;
   localparam opcode_type OP_REINIT = 2'd2;

   // reported states
   localparam mode_type MODE_NORMAL  = 2'd0;
   localparam mode_type MODE_WARNING = 2'd1;
   localparam mode_type MODE_ALARM   = 2'd2;
   localparam mode_type MODE_ERROR   = 2'd3;

   localparam count_type COUNT_MAX = 8'd255;

   // register indexes
   localparam csr_addr_type CSR_CO_ALARM   = 3'd0;
   localparam csr_addr_type CSR_CO_WARNING = 3'd1;
   localparam csr_addr_type CSR_CO_EXIT    = 3'd2;
   localparam csr_addr_type CSR_T_ALARM    = 3'd3;
   localparam csr_addr_type CSR_T_WARNING  = 3'd4;
   localparam csr_addr_type CSR_T_EXIT     = 3'd5;
   localparam csr_addr_type CSR_ENTER_LIM  = 3'd6;
   localparam csr_addr_type CSR_EXIT_LIM   = 3'd7;

   // register reset values
   localparam ppm_type   RST_CO_ALARM   = 16'd150;
   localparam ppm_type   RST_CO_WARNING = 16'd50;
   localparam ppm_type   RST_CO_EXIT    = 16'd35;
   localparam temp_type  RST_T_ALARM    = 16'sd960;
   localparam temp_type  RST_T_WARNING  = 16'sd720;
   localparam temp_type  RST_T_EXIT     = 16'sd800;
   localparam count_type RST_ENTER_LIM  = 8'd3;
   localparam count_type RST_EXIT_LIM   = 8'd5;

   // counter limits, handed from front to back
   typedef struct packed {
      count_type enter_limit;
      count_type exit_limit;
   } limits_type;

   // classified word passed through the queue
   typedef struct packed {
      opcode_type opcode;
      logic       hot;
      logic       warm;
      logic       calm;
   } cls_type;

endpackage

### rtl/ghaq_if.sv
// ghaq_if: valid/ready channel interfaces for request, response and CSR words.
// Depends on ghaq_pkg for payload types.
interface ghaq_req_if;
   logic                 valid;
   logic                 ready;
   ghaq_pkg::opcode_type opcode;
   ghaq_pkg::ppm_type    co_level;
   ghaq_pkg::temp_type   temperature;

   modport source (output valid, output opcode, output co_level, output temperature,
                   input ready);
   modport sink   (input valid, input opcode, input co_level, input temperature,
                   output ready);
endinterface

interface ghaq_rsp_if;
   logic                valid;
   logic                ready;
   ghaq_pkg::mode_type  alarm_state;
   ghaq_pkg::count_type enter_count;
   ghaq_pkg::count_type exit_count;

   modport source (output valid, output alarm_state, output enter_count, output exit_count,
                   input ready);
   modport sink   (input valid, input alarm_state, input enter_count, input exit_count,
                   output ready);
endinterface

interface ghaq_csr_if;
   logic                   valid;
   logic                   ready;
   ghaq_pkg::csr_addr_type addr;
   ghaq_pkg::csr_data_type data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

### rtl/gas_heat_alarm_qualifier.sv
// gas_heat_alarm_qualifier: top level of the CO / temperature alarm qualifier.
// Depends on ghaq_pkg, ghaq_if, ghaq_front, ghaq_queue and ghaq_back.
//
// Usage
//   req_bus : sample words {opcode, co_level, temperature}; opcode evaluates a
//             sample, forces the sticky error state or reinitialises to normal.
//   rsp_bus : one word per request {alarm_state, enter_count, exit_count},
//             in request order, showing state after that request.
//   csr_bus : register writes {addr, data}, always ready; write only while
//             the block is idle. All eight addresses are decoded.
//   Path    : a request is queued, popped once the response register is free.
//   Rate    : one word per cycle sustained while rsp_bus.ready is high. The
//             front classifies in the cycle of acceptance (six compares); the
//             back updates the state and both saturating counters in the cycle
//             it pops the queue.
//   Stall   : the response register holds while rsp_bus.ready is low; the
//             queue (QUEUE_DEPTH words) keeps absorbing requests until full,
//             then req_bus.ready drops.
//   Reset   : synchronous; state normal, counters zero, thresholds back to
//             their default values, queue and response register emptied.
module gas_heat_alarm_qualifier #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   ghaq_req_if.sink   req_bus,
   ghaq_rsp_if.source rsp_bus,
   ghaq_csr_if.sink   csr_bus
);

   ghaq_pkg::cls_type    push_word;
   ghaq_pkg::cls_type    head;
   ghaq_pkg::limits_type limits;
   logic                 push;
   logic                 pop;
   logic                 q_full;
   logic                 q_not_empty;

   // front: CSRs and classification
   ghaq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr       (csr_bus),
      .q_full    (q_full),
      .push      (push),
      .push_word (push_word),
      .limits    (limits)
   );

   // decoupling queue
   ghaq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // back: state update and response
   ghaq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .head        (head),
      .limits      (limits),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

### rtl/ghaq_front.sv
// ghaq_front: CSR file and sample classifier; pushes classified words to the queue.
// Depends on ghaq_pkg and ghaq_if.
module ghaq_front (
   input  logic                 clock,
   input  logic                 reset,
   ghaq_req_if.sink             req,
   ghaq_csr_if.sink             csr,
   input  logic                 q_full,
   output logic                 push,
   output ghaq_pkg::cls_type    push_word,
   output ghaq_pkg::limits_type limits
);

   ghaq_pkg::ppm_type   co_alarm_ff,   co_alarm_in;
   ghaq_pkg::ppm_type   co_warning_ff, co_warning_in;
   ghaq_pkg::ppm_type   co_exit_ff,    co_exit_in;
   ghaq_pkg::temp_type  t_alarm_ff,    t_alarm_in;
   ghaq_pkg::temp_type  t_warning_ff,  t_warning_in;
   ghaq_pkg::temp_type  t_exit_ff,     t_exit_in;
   ghaq_pkg::count_type enter_lim_ff,  enter_lim_in;
   ghaq_pkg::count_type exit_lim_ff,   exit_lim_in;

   assign csr.ready = 1'b1;

   always_comb begin
      co_alarm_in   = co_alarm_ff;
      co_warning_in = co_warning_ff;
      co_exit_in    = co_exit_ff;
      t_alarm_in    = t_alarm_ff;
      t_warning_in  = t_warning_ff;
      t_exit_in     = t_exit_ff;
      enter_lim_in  = enter_lim_ff;
      exit_lim_in   = exit_lim_ff;
      if (csr.valid) begin
         case (csr.addr)
            ghaq_pkg::CSR_CO_ALARM:   co_alarm_in   = csr.data;
            ghaq_pkg::CSR_CO_WARNING: co_warning_in = csr.data;
            ghaq_pkg::CSR_CO_EXIT:    co_exit_in    = csr.data;
            ghaq_pkg::CSR_T_ALARM:    t_alarm_in    = $signed(csr.data);
            ghaq_pkg::CSR_T_WARNING:  t_warning_in  = $signed(csr.data);
            ghaq_pkg::CSR_T_EXIT:     t_exit_in     = $signed(csr.data);
            ghaq_pkg::CSR_ENTER_LIM:  enter_lim_in  = csr.data[7:0];
            ghaq_pkg::CSR_EXIT_LIM:   exit_lim_in   = csr.data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         co_alarm_ff   <= ghaq_pkg::RST_CO_ALARM;
         co_warning_ff <= ghaq_pkg::RST_CO_WARNING;
         co_exit_ff    <= ghaq_pkg::RST_CO_EXIT;
         t_alarm_ff    <= ghaq_pkg::RST_T_ALARM;
         t_warning_ff  <= ghaq_pkg::RST_T_WARNING;
         t_exit_ff     <= ghaq_pkg::RST_T_EXIT;
         enter_lim_ff  <= ghaq_pkg::RST_ENTER_LIM;
         exit_lim_ff   <= ghaq_pkg::RST_EXIT_LIM;
      end else begin
         co_alarm_ff   <= co_alarm_in;
         co_warning_ff <= co_warning_in;
         co_exit_ff    <= co_exit_in;
         t_alarm_ff    <= t_alarm_in;
         t_warning_ff  <= t_warning_in;
         t_exit_ff     <= t_exit_in;
         enter_lim_ff  <= enter_lim_in;
         exit_lim_ff   <= exit_lim_in;
      end
   end

   assign limits.enter_limit = enter_lim_ff;
   assign limits.exit_limit  = exit_lim_ff;

   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   // six compares, all exact
   assign push_word.opcode = req.opcode;
   assign push_word.hot    = (req.co_level > co_alarm_ff)   || (req.temperature > t_alarm_ff);
   assign push_word.warm   = (req.co_level > co_warning_ff) || (req.temperature > t_warning_ff);
   assign push_word.calm   = (req.co_level < co_exit_ff)    && (req.temperature < t_exit_ff);

endmodule

### rtl/ghaq_queue.sv
// ghaq_queue: short FIFO of classified words between front and back.
// Depends on ghaq_pkg for the word type.
module ghaq_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ghaq_pkg::cls_type push_word,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output ghaq_pkg::cls_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ghaq_pkg::cls_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/ghaq_back.sv
// ghaq_back: alarm state machine, saturating counters and response register.
// Depends on ghaq_pkg and ghaq_if.
module ghaq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  ghaq_pkg::cls_type    head,
   input  ghaq_pkg::limits_type limits,
   output logic                 pop,
   ghaq_rsp_if.source           rsp
);

   ghaq_pkg::mode_type  mode_ff,  mode_in;
   ghaq_pkg::count_type enter_ff, enter_in;
   ghaq_pkg::count_type exit_ff,  exit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ghaq_pkg::count_type enter_inc, exit_inc;

   assign pop = q_not_empty && (!rsp_valid_ff || rsp.ready);

   assign enter_inc = (enter_ff == ghaq_pkg::COUNT_MAX) ? enter_ff : enter_ff + 8'd1;
   assign exit_inc  = (exit_ff  == ghaq_pkg::COUNT_MAX) ? exit_ff  : exit_ff  + 8'd1;

   always_comb begin
      mode_in  = mode_ff;
      enter_in = enter_ff;
      exit_in  = exit_ff;
      case (head.opcode)
         ghaq_pkg::OP_EVAL: begin
            if (mode_ff != ghaq_pkg::MODE_ERROR) begin
               if (head.hot) begin
                  enter_in = enter_inc;
                  exit_in  = '0;
                  if (enter_inc >= limits.enter_limit) begin
                     mode_in = ghaq_pkg::MODE_ALARM;
                  end
               end else begin
                  enter_in = '0;
                  if (mode_ff == ghaq_pkg::MODE_ALARM) begin
                     if (head.calm) begin
                        exit_in = exit_inc;
                        if (exit_inc >= limits.exit_limit) begin
                           mode_in = head.warm ? ghaq_pkg::MODE_WARNING
                                               : ghaq_pkg::MODE_NORMAL;
                           exit_in = '0;
                        end
                     end else begin
                        exit_in = '0;
                     end
                  end else begin
                     exit_in = '0;
                     mode_in = head.warm ? ghaq_pkg::MODE_WARNING : ghaq_pkg::MODE_NORMAL;
                  end
               end
            end
         end
         ghaq_pkg::OP_ERROR: begin
            mode_in = ghaq_pkg::MODE_ERROR;
         end
         ghaq_pkg::OP_REINIT: begin
            mode_in  = ghaq_pkg::MODE_NORMAL;
            enter_in = '0;
            exit_in  = '0;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ghaq_pkg::MODE_NORMAL;
         enter_ff     <= '0;
         exit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff  <= mode_in;
            enter_ff <= enter_in;
            exit_ff  <= exit_in;
         end
      end
   end

   // the state registers double as the response payload
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.alarm_state = mode_ff;
   assign rsp.enter_count = enter_ff;
   assign rsp.exit_count  = exit_ff;

endmodule

### rtl/ghaq_checker.sv
// ghaq_checker: port-level assertions for gas_heat_alarm_qualifier, plus its bind.
// Depends on ghaq_pkg; bound to the top level below.
module ghaq_checker #(
   parameter int MAX_OUTSTANDING = 3
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ghaq_pkg::mode_type  alarm_state,
   input ghaq_pkg::count_type enter_count,
   input ghaq_pkg::count_type exit_count
);

   localparam int OUT_W = $clog2(MAX_OUTSTANDING + 1) + 1;

   logic [OUT_W-1:0] outstanding_ff, outstanding_in;
   logic             req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // no response is shown straight after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no response without a request behind it, and no more in flight than storage
   a_no_invented_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != '0))
      else $error("response with no outstanding request");

   a_bounded_in_flight: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_W'(MAX_OUTSTANDING))
      else $error("more words in flight than the block can hold");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(alarm_state)
         && $stable(enter_count) && $stable(exit_count))
      else $error("stalled response changed");

   // the counters are never both running, and outside alarm/error exit count is clear
   a_counter_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((enter_count == '0) || (exit_count == '0))
         && (((alarm_state != ghaq_pkg::MODE_NORMAL)
              && (alarm_state != ghaq_pkg::MODE_WARNING)) || (exit_count == '0)))
      else $error("inconsistent counter values");

endmodule

bind gas_heat_alarm_qualifier ghaq_checker #(
   .MAX_OUTSTANDING (QUEUE_DEPTH + 1)
) u_ghaq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .alarm_state (rsp_bus.alarm_state),
   .enter_count (rsp_bus.enter_count),
   .exit_count  (rsp_bus.exit_count)
);
